### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file hbst_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HBST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define HBST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### hdl/hbst_pkg.sv
// ----------------------------------------------------------------------------
// hbst_pkg
// Types, constants and helpers of the hash bucket slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package hbst_pkg;

    localparam int SLOTS    = 32;
    localparam int IDX_W    = 5;
    localparam int KEY_BITS = 32;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 6;
    localparam int CODE_W   = 3;
    localparam int SLOT_W   = 5;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 48;

    typedef enum logic [1:0] {
        CMD_LOOKUP    = 2'd0,
        CMD_INSERT    = 2'd1,
        CMD_REMOVE    = 2'd2,
        CMD_INSERT_AT = 2'd3
    } cmd_t;

    typedef enum logic [CODE_W-1:0] {
        RES_OK        = 3'd0,
        RES_NOT_FOUND = 3'd1,
        RES_DUPLICATE = 3'd2,
        RES_FULL      = 3'd3,
        RES_SLOT_LIVE = 3'd4
    } res_code_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic final_step;
    } dp_status_t;

    // lowest set bit; zero when none
    function automatic logic [IDX_W-1:0] first_set(input logic [SLOTS-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### hdl/hash_bucket_slot_table_top.sv
// ----------------------------------------------------------------------------
// hash_bucket_slot_table_top
// One bucket of 32 key/value slots with tombstones: lookup, insert, remove
// and insert at a given slot over a streaming command/result interface.
// ----------------------------------------------------------------------------
// A command is accepted when s_tvalid and s_tready are both high, and its key
// and value are compared against all live slots in that same cycle. The
// compare is registered; each result is then chosen by a priority select,
// together with any slot update, and loaded into the output register. Insert,
// remove and insert-at yield one item; a lookup with n matches yields n items,
// one per cycle in slot order while m_tready stays high (one not-found item
// when n is 0). Each result waits while the result side holds m_tready low. A
// new command is taken once the last result of the previous one sits in the
// output register.
`default_nettype none

module hash_bucket_slot_table_top
    import hbst_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // cmd[1:0], key[33:2], value[65:34], slot[70:66], zero pad [71]
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // result_code[2:0], value_out[34:3], full_res[35], empty_res[36],
    // live_count[42:37], zero pad [47:43]
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    hbst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    hbst_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (dp_cmd),
        .status   (dp_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### hdl/hbst_ctrl.sv
// ----------------------------------------------------------------------------
// hbst_ctrl
// Command sequencer: accepts an item, then steps the datapath until the
// final result of the command has been loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbst_ctrl
    import hbst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.out_free && status.final_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.step    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/hbst_datapath.sv
// ----------------------------------------------------------------------------
// hbst_datapath
// Slot storage, parallel key/value compare, priority select, live count and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbst_datapath
    import hbst_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IN_W-1:0]   s_tdata,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    output logic                   m_tlast
);

    // input fields
    cmd_t                in_cmd;
    logic [KEY_BITS-1:0] in_key;
    logic [VAL_W-1:0]    in_value;
    logic [SLOT_W-1:0]   in_slot;

    assign in_cmd   = cmd_t'(s_tdata[1:0]);
    assign in_key   = s_tdata[2 +: KEY_BITS];
    assign in_value = s_tdata[34 +: VAL_W];
    assign in_slot  = s_tdata[66 +: SLOT_W];

    // slot storage
    logic [KEY_BITS-1:0] key_mem [SLOTS];
    logic [VAL_W-1:0]    val_mem [SLOTS];
    logic [SLOTS-1:0]    live_reg;
    logic [SLOTS-1:0]    live_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // captured command
    cmd_t                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VAL_W-1:0]    value_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOTS-1:0]    hit_reg;
    logic [SLOTS-1:0]    hit_next;
    logic [SLOTS-1:0]    pair_reg;
    logic [SLOTS-1:0]    pair_next;
    logic [SLOTS-1:0]    free_reg;

    // execute
    logic [IDX_W-1:0]    lk_idx;
    logic [SLOTS-1:0]    lk_rest;
    logic [SLOTS-1:0]    ins_vec;
    logic [IDX_W-1:0]    ins_idx;
    logic [IDX_W-1:0]    rm_idx;
    logic [IDX_W-1:0]    at_idx;
    res_code_t           res_code;
    logic [VAL_W-1:0]    res_value;
    logic                res_last;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;

    // output register
    logic                m_tvalid_reg;
    res_code_t           code_reg;
    logic [VAL_W-1:0]    vout_reg;
    logic                last_reg;
    logic                full_reg;
    logic                empty_reg;
    logic [CNT_W-1:0]    cnt_out_reg;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_next[i]  = live_reg[i] && (key_mem[i] == in_key);
            pair_next[i] = hit_next[i] && (val_mem[i] == in_value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_cmd;
            key_reg   <= in_key;
            value_reg <= in_value;
            slot_reg  <= in_slot;
            pair_reg  <= pair_next;
            free_reg  <= ~live_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hit_reg <= hit_next;
        end
        else if (cmd.step)
        begin
            hit_reg <= lk_rest;
        end
    end

    assign lk_idx  = first_set(hit_reg);
    assign lk_rest = hit_reg & ~(SLOTS'(1) << lk_idx);
    assign ins_vec = free_reg | pair_reg;
    assign ins_idx = first_set(ins_vec);
    assign rm_idx  = first_set(pair_reg);
    assign at_idx  = slot_reg[IDX_W-1:0];

    always_comb
    begin
        res_code   = RES_OK;
        res_value  = '0;
        res_last   = 1'b1;
        live_next  = live_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_idx     = ins_idx;
        unique case (op_reg)
            CMD_LOOKUP:
            begin
                if (hit_reg == '0)
                begin
                    res_code = RES_NOT_FOUND;
                end
                else
                begin
                    res_value = val_mem[lk_idx];
                    res_last  = (lk_rest == '0);
                end
            end
            CMD_INSERT:
            begin
                if (ins_vec == '0)
                begin
                    res_code = RES_FULL;
                end
                else if (free_reg[ins_idx])
                begin
                    wr_en             = 1'b1;
                    live_next[ins_idx] = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                end
                else
                begin
                    res_code = RES_DUPLICATE;
                end
            end
            CMD_REMOVE:
            begin
                if (pair_reg != '0)
                begin
                    live_next[rm_idx] = 1'b0;
                    count_next        = count_reg - CNT_W'(1);
                end
                else
                begin
                    res_code = RES_NOT_FOUND;
                end
            end
            CMD_INSERT_AT:
            begin
                if (CNT_W'(slot_reg) >= CNT_W'(SLOTS))
                begin
                    res_code = RES_NOT_FOUND;
                end
                else if (live_reg[at_idx])
                begin
                    res_code = RES_SLOT_LIVE;
                end
                else
                begin
                    wr_en             = 1'b1;
                    wr_idx            = at_idx;
                    live_next[at_idx] = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                res_code = RES_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            live_reg  <= live_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && wr_en)
        begin
            key_mem[wr_idx] <= key_reg;
            val_mem[wr_idx] <= value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            code_reg    <= res_code;
            vout_reg    <= res_value;
            last_reg    <= res_last;
            full_reg    <= (count_next == CNT_W'(SLOTS));
            empty_reg   <= (count_next == '0);
            cnt_out_reg <= count_next;
        end
    end

    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign status.final_step = (op_reg != CMD_LOOKUP) || (hit_reg == '0) || (lk_rest == '0);

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'b0, cnt_out_reg, empty_reg, full_reg, vout_reg, code_reg};

endmodule

`default_nettype wire

### hdl/hbst_checker.sv
// ----------------------------------------------------------------------------
// hbst_checker
// Port-level checks of the slot table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hbst_checker
    import hbst_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             m_tlast
);

    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  vout;
    logic              full_f;
    logic              empty_f;
    logic [CNT_W-1:0]  cnt;

    assign code    = m_tdata[2:0];
    assign vout    = m_tdata[34:3];
    assign full_f  = m_tdata[35];
    assign empty_f = m_tdata[36];
    assign cnt     = m_tdata[42:37];

    // a not-found item closes its command
    `HBST_ASSERT_IMPL(a_notfound_last, clk, rst_n, m_tvalid && (code == RES_NOT_FOUND), m_tlast)

    // only a hit carries a value
    `HBST_ASSERT_IMPL(a_value_zero, clk, rst_n, m_tvalid && (code != RES_OK), vout == '0)

    // flags agree with the count
    `HBST_ASSERT_IMPL(a_flags_count, clk, rst_n, m_tvalid,
        (full_f == (cnt == CNT_W'(SLOTS))) && (empty_f == (cnt == '0)))

    // one command in flight at a time
    `HBST_ASSERT_NEXT(a_one_cmd, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // stalled result holds
    `HBST_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind hash_bucket_slot_table_top hbst_checker u_hbst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
